FILE: design/nau_pkg.sv
// Shared types and fixed constants of the neural activation unit.
package nau_pkg;

   // Activation function selected by the mode register
   typedef enum logic [1:0] {
      MODE_SIGMOID  = 2'd0,
      MODE_TANH     = 2'd1,
      MODE_RELU     = 2'd2,
      MODE_IDENTITY = 2'd3
   } mode_type;

   // Element width and the widths that follow from it
   localparam int X_W   = 16;           // signed element
   localparam int MAG_W = X_W + 1;      // magnitude of x or 2x
   localparam int TAB_W = 30;           // table entry, unsigned Q30 below 1.0
   localparam int S_W   = 31;           // Q30 value up to and including 1.0
   localparam int V_W   = 32;           // signed Q30 value with rounding headroom

   // Table spans 0 to 2^SPAN_LOG2
   localparam int SPAN_LOG2 = 3;

   localparam logic [S_W-1:0] Q30_ONE = S_W'(1) << 30;

   // Sideband that travels with each element down the pipe
   typedef struct packed {
      logic                  action;  // 1: derivative
      mode_type              mode;
      logic                  neg;     // table operand was negative
      logic                  last;
      logic signed [X_W-1:0] x;
   } side_type;

endpackage

FILE: design/nau_lookup.sv
// Sigmoid table front end: address generation, table read and linear interpolation.
module nau_lookup #(
   parameter int FRAC_BITS   = 12,
   parameter int TABLE_DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  nau_pkg::side_type         in_side,
   output logic                      out_valid,
   input  logic                      out_ready,
   output nau_pkg::side_type         out_side,
   output logic [nau_pkg::TAB_W-1:0] out_lo,
   output logic [nau_pkg::TAB_W-1:0] out_interp
);
   import nau_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH + 1);
   localparam int P_W    = MAG_W + IDX_W;
   localparam int FSH    = FRAC_BITS + SPAN_LOG2;   // log2 of the whole table span in input lsbs
   localparam int PROD_W = TAB_W + FSH;

   // One table step in Q30
   localparam logic [63:0] TAB_STEP = (64'(1) << (30 + SPAN_LOG2)) / 64'(TABLE_DEPTH);

   typedef logic [TAB_W-1:0] tab_type [TABLE_DEPTH+1];

   // Unsigned quotient by shift and subtract, for building the table
   function automatic logic [63:0] quot64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem  = rem - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Entry k is 1 / (1 + exp(-k * span / depth)) in Q30, built by recurrence
   function automatic tab_type build_table();
      tab_type            t;
      logic [63:0]        term;
      logic [63:0]        e;
      logic signed [63:0] r;
      term = 64'(1) << 30;
      r    = 64'(1) << 30;
      e    = 64'(1) << 30;
      // exp(-step) by its Taylor series
      for (int n = 1; n <= 24; n++) begin
         term = quot64(term * TAB_STEP, 64'(n) << 30);
         if (n[0]) begin
            r = r - $signed(term);
         end else begin
            r = r + $signed(term);
         end
      end
      if (r < 0) begin
         r = 0;
      end
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
         if (k > 0) begin
            e = (e * $unsigned(r) + (64'(1) << 29)) >> 30;
         end
         t[k] = TAB_W'(quot64(64'(1) << 60, (64'(1) << 30) + e));
      end
      return t;
   endfunction

   localparam tab_type SIG_ROM = build_table();

   // Stage ready chain: a stage loads when empty or when the next one moves
   logic rdy1, rdy2, rdy3;
   logic v1_ff, v2_ff, v3_ff;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // Stage 1: operand, magnitude, table index and fraction
   logic signed [MAG_W-1:0] oper;
   logic [MAG_W-1:0]        mag;
   logic [P_W-1:0]          pos;
   logic [P_W-1:0]          pidx;
   logic                    beyond;
   logic [IDX_W-1:0]        idx_lo_in, idx_hi_in;
   logic [FSH-1:0]          frac_in;
   side_type                side1_in;

   always_comb begin
      if (in_side.mode == MODE_TANH) begin
         oper = {in_side.x, 1'b0};
      end else begin
         oper = MAG_W'(in_side.x);
      end
      mag    = oper[MAG_W-1] ? (~oper + MAG_W'(1)) : oper;
      pos    = P_W'(mag) * P_W'(TABLE_DEPTH);
      pidx   = pos >> FSH;
      beyond = pidx >= P_W'(TABLE_DEPTH);
      if (beyond) begin
         // saturated end of the table, no interpolation
         idx_lo_in = IDX_W'(TABLE_DEPTH);
         idx_hi_in = IDX_W'(TABLE_DEPTH);
         frac_in   = '0;
      end else begin
         idx_lo_in = pidx[IDX_W-1:0];
         idx_hi_in = pidx[IDX_W-1:0] + IDX_W'(1);
         frac_in   = pos[FSH-1:0];
      end
      side1_in     = in_side;
      side1_in.neg = oper[MAG_W-1];
   end

   logic [IDX_W-1:0] idx_lo_ff, idx_hi_ff;
   logic [FSH-1:0]   frac1_ff;
   side_type         side1_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         idx_lo_ff <= idx_lo_in;
         idx_hi_ff <= idx_hi_in;
         frac1_ff  <= frac_in;
         side1_ff  <= side1_in;
      end
   end

   // Stage 2: registered table read of both neighbours
   logic [TAB_W-1:0] lo2_ff, hi2_ff;
   logic [FSH-1:0]   frac2_ff;
   side_type         side2_ff;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         lo2_ff   <= SIG_ROM[idx_lo_ff];
         hi2_ff   <= SIG_ROM[idx_hi_ff];
         frac2_ff <= frac1_ff;
         side2_ff <= side1_ff;
      end
   end

   // Stage 3: interpolation step, slope times fraction
   logic [TAB_W-1:0]  diff;
   logic [PROD_W-1:0] prod;
   logic [TAB_W-1:0]  interp_in;

   always_comb begin
      diff      = (hi2_ff >= lo2_ff) ? (hi2_ff - lo2_ff) : '0;
      prod      = PROD_W'(diff) * PROD_W'(frac2_ff);
      interp_in = TAB_W'(prod >> FSH);
   end

   logic [TAB_W-1:0] lo3_ff, interp3_ff;
   side_type         side3_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         lo3_ff     <= lo2_ff;
         interp3_ff <= interp_in;
         side3_ff   <= side2_ff;
      end
   end

   assign out_valid  = v3_ff;
   assign out_side   = side3_ff;
   assign out_lo     = lo3_ff;
   assign out_interp = interp3_ff;

endmodule

FILE: design/nau_shape.sv
// Back end: sigmoid, tanh and derivative forming, ReLU and identity select, rounding, saturation and output register.
module nau_shape #(
   parameter int FRAC_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  nau_pkg::side_type                in_side,
   input  logic [nau_pkg::TAB_W-1:0]        in_lo,
   input  logic [nau_pkg::TAB_W-1:0]        in_interp,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [nau_pkg::X_W-1:0]   out_y,
   output logic                             out_last
);
   import nau_pkg::*;

   localparam int SH = 30 - FRAC_BITS;
   localparam logic signed [V_W-1:0] HALF   = V_W'(1) << (SH - 1);
   localparam logic signed [V_W-1:0] ONE_V  = V_W'(Q30_ONE);
   localparam logic signed [V_W-1:0] Y_MAX  = V_W'(32767);
   localparam logic signed [V_W-1:0] Y_MIN  = -V_W'(32768);
   localparam logic signed [X_W-1:0] ONE_Y  =
      (FRAC_BITS >= X_W - 1) ? X_W'(32767) : X_W'(1 << FRAC_BITS);

   logic rdy4, rdy5, rdy6, rdy7;
   logic v4_ff, v5_ff, v6_ff, v7_ff;

   assign rdy7     = !v7_ff || out_ready;
   assign rdy6     = !v6_ff || rdy7;
   assign rdy5     = !v5_ff || rdy6;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (rdy4) begin
            v4_ff <= in_valid;
         end
         if (rdy5) begin
            v5_ff <= v4_ff;
         end
         if (rdy6) begin
            v6_ff <= v5_ff;
         end
         if (rdy7) begin
            v7_ff <= v6_ff;
         end
      end
   end

   // Stage 4: sigmoid magnitude of |operand|
   logic [S_W-1:0] s4_ff;
   side_type       side4_ff;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_ff    <= S_W'(in_lo) + S_W'(in_interp);
         side4_ff <= in_side;
      end
   end

   // Stage 5: signed value and multiplier operands
   logic [S_W:0]           s2;
   logic [S_W-1:0]         sc;
   logic [S_W-1:0]         at;
   logic signed [V_W-1:0]  vq_in;
   logic [S_W-1:0]         ma_in, mb_in;

   always_comb begin
      s2    = {s4_ff, 1'b0};
      sc    = Q30_ONE - s4_ff;
      at    = (s2 >= (S_W+1)'(Q30_ONE)) ? S_W'(s2 - (S_W+1)'(Q30_ONE))
                                        : S_W'((S_W+1)'(Q30_ONE) - s2);
      vq_in = '0;
      ma_in = '0;
      mb_in = '0;
      case (side4_ff.mode)
         MODE_SIGMOID: begin
            vq_in = side4_ff.neg ? V_W'(sc) : V_W'(s4_ff);
            ma_in = s4_ff;
            mb_in = sc;
         end
         MODE_TANH: begin
            // tanh = 2s - 1, mirrored for a negative operand
            vq_in = side4_ff.neg ? (ONE_V - V_W'(s2)) : (V_W'(s2) - ONE_V);
            ma_in = at;
            mb_in = at;
         end
         default: begin
            vq_in = '0;
         end
      endcase
   end

   logic signed [V_W-1:0] vq5_ff;
   logic [S_W-1:0]        ma5_ff, mb5_ff;
   side_type              side5_ff;

   always_ff @(posedge clock) begin
      if (rdy5) begin
         vq5_ff   <= vq_in;
         ma5_ff   <= ma_in;
         mb5_ff   <= mb_in;
         side5_ff <= side4_ff;
      end
   end

   // Stage 6: s(1-s) or t*t product, back to Q30
   logic [2*S_W-1:0]      prod;
   logic [S_W-1:0]        prod6_ff;
   logic signed [V_W-1:0] vq6_ff;
   side_type              side6_ff;

   assign prod = (2*S_W)'(ma5_ff) * (2*S_W)'(mb5_ff);

   always_ff @(posedge clock) begin
      if (rdy6) begin
         prod6_ff <= S_W'(prod >> 30);
         vq6_ff   <= vq5_ff;
         side6_ff <= side5_ff;
      end
   end

   // Stage 7: select, round half up to FRAC_BITS, saturate
   logic signed [V_W-1:0] q_round;
   logic signed [V_W-1:0] q_shift;
   logic signed [X_W-1:0] y_sat;
   logic signed [X_W-1:0] y_in;

   always_comb begin
      q_round = vq6_ff + HALF;
      if (side6_ff.action) begin
         if (side6_ff.mode == MODE_TANH) begin
            q_round = (ONE_V + HALF) - V_W'(prod6_ff);
         end else begin
            q_round = V_W'(prod6_ff) + HALF;
         end
      end
      q_shift = q_round >>> SH;
      if (q_shift > Y_MAX) begin
         y_sat = X_W'(Y_MAX);
      end else if (q_shift < Y_MIN) begin
         y_sat = X_W'(Y_MIN);
      end else begin
         y_sat = X_W'(q_shift);
      end
      case (side6_ff.mode)
         MODE_SIGMOID, MODE_TANH: begin
            y_in = y_sat;
         end
         MODE_RELU: begin
            if (side6_ff.x > 0) begin
               y_in = side6_ff.action ? ONE_Y : side6_ff.x;
            end else begin
               y_in = '0;
            end
         end
         default: begin
            y_in = side6_ff.action ? ONE_Y : side6_ff.x;
         end
      endcase
   end

   logic signed [X_W-1:0] y7_ff;
   logic                  last7_ff;

   always_ff @(posedge clock) begin
      if (rdy7) begin
         y7_ff    <= y_in;
         last7_ff <= side6_ff.last;
      end
   end

   assign out_valid = v7_ff;
   assign out_y     = y7_ff;
   assign out_last  = last7_ff;

endmodule

FILE: design/neural_activation_unit.sv
// Top level of the neural activation unit: register port, pipeline halves and checks.
//
// Streams signed Q4.12 elements (FRAC_BITS fraction bits) and returns one result per
// element: sigmoid, tanh, ReLU or identity as chosen by the mode register at byte
// address 0, or its derivative when req_action is 1. The unit takes one beat per clock
// while req_stall is low and returns results in order. The lookup half does table
// addressing, the registered sigmoid table read and the interpolation multiply; the
// shape half forms tanh and the derivatives, the 31x31 product, and rounding with
// saturation into the output register. Empty stages close up under rsp_stall, so
// req_stall rises only when all seven stages hold a beat. The sigmoid table holds
// TABLE_DEPTH+1 constant entries over inputs 0 to 8.0. Write the mode only while no
// beat is in flight.
module neural_activation_unit #(
   parameter int FRAC_BITS   = 12,
   parameter int TABLE_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   // element input
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic signed [nau_pkg::X_W-1:0] req_x_value,
   input  logic                           req_last_in,
   // result output
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [nau_pkg::X_W-1:0] rsp_y_value,
   output logic                           rsp_last_out,
   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [1:0]                     paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import nau_pkg::*;

   // Mode register; the single register fills the whole 4-byte window
   mode_type mode_ff;
   logic     csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SIGMOID;
      end else if (csr_write && (paddr[1:0] >> 2) == 2'd0) begin
         mode_ff <= mode_type'(pwdata[1:0]);
      end
   end

   assign prdata = {30'd0, mode_ff};

   // Pipeline halves
   side_type         req_side;
   side_type         mid_side;
   logic             lk_ready;
   logic             mid_valid, mid_ready;
   logic [TAB_W-1:0] mid_lo, mid_interp;

   always_comb begin
      req_side.action = req_action;
      req_side.mode   = mode_ff;
      req_side.neg    = 1'b0;
      req_side.last   = req_last_in;
      req_side.x      = req_x_value;
   end

   nau_lookup #(
      .FRAC_BITS   (FRAC_BITS),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_lookup (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (lk_ready),
      .in_side    (req_side),
      .out_valid  (mid_valid),
      .out_ready  (mid_ready),
      .out_side   (mid_side),
      .out_lo     (mid_lo),
      .out_interp (mid_interp)
   );

   nau_shape #(
      .FRAC_BITS (FRAC_BITS)
   ) u_shape (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_side   (mid_side),
      .in_lo     (mid_lo),
      .in_interp (mid_interp),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_y     (rsp_y_value),
      .out_last  (rsp_last_out)
   );

   assign req_stall = !lk_ready;

   // Checks
   // input backs up only when the output beat is held
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall raised while output is not stalled");

   // a register write lands in the mode register
   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (mode_ff == mode_type'($past(pwdata[1:0]))))
      else $error("mode register did not take the written value");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule
